>>> rtl/sbfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_pkg
// Shared types and constants for the sync byte frame deframer.
// ----------------------------------------------------------------------------
package sbfd_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_VALUE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PAYLOAD  = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [7:0]  SYNC_RESET    = 8'hA5;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1400;

  // Header layout: type, flags, two length bytes, two sequence bytes, checksum.
  localparam int unsigned HDR_FIELD_BYTES = 1 + 1 + 2 + 2;
  localparam logic [2:0]  HDR_TYPE     = 3'd0;
  localparam logic [2:0]  HDR_FLAGS    = 3'd1;
  localparam logic [2:0]  HDR_LEN_HI   = 3'd2;
  localparam logic [2:0]  HDR_LEN_LO   = 3'd3;
  localparam logic [2:0]  HDR_SEQ_HI   = 3'd4;
  localparam logic [2:0]  HDR_SEQ_LO   = 3'd5;
  localparam logic [2:0]  HDR_CHECKSUM = 3'(HDR_FIELD_BYTES);

  // Parser phase.
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // One result beat.
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic        frame_done;
    logic        checksum_ok;
    logic        length_error;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] frame_seq;
    logic [15:0] frame_length;
  } result_t;

endpackage

>>> rtl/sync_byte_frame_deframer.sv
`timescale 1ns / 1ps
// Path: an accepted byte waits in the input register, is parsed from there, and
// its result beat goes into the result register, which holds it until taken.
// Throughput: one byte per cycle while result beats are taken; a stalled
// result register holds back the input.
// Reset: synchronous, active low; the parser hunts for sync, registers return
// to sync 0xA5 and length limit 1400, both stages empty.
// ----------------------------------------------------------------------------
// sync_byte_frame_deframer
// Sync-byte framed deframer with header parsing and an 8-bit sum check.
// ----------------------------------------------------------------------------
module sync_byte_frame_deframer import sbfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_payload_valid,
  output logic [7:0]            out_payload_byte,
  output logic [15:0]           out_byte_index,
  output logic                  out_frame_done,
  output logic                  out_checksum_ok,
  output logic                  out_length_error,
  output logic [7:0]            out_frame_type,
  output logic [7:0]            out_frame_flags,
  output logic [15:0]           out_frame_seq,
  output logic [15:0]           out_frame_length
);

  logic [7:0]  sync_value_r;
  logic [15:0] max_len_r;
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        can_load;
  logic        step_en;
  result_t     step_result;
  result_t     out_result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r <= SYNC_RESET;
      max_len_r    <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SYNC_VALUE:  sync_value_r <= cfg_wdata[7:0];
        CFG_MAX_PAYLOAD: max_len_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Input register; a held byte moves into the parser when the result
  // register can take its beat.
  assign step_en  = in_valid_r && can_load;
  assign in_ready = !in_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  sbfd_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (step_en),
    .rx_byte         (in_byte_r),
    .sync_value      (sync_value_r),
    .max_payload_len (max_len_r),
    .result          (step_result)
  );

  sbfd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en),
    .result_in  (step_result),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .can_load   (can_load),
    .result_out (out_result)
  );

  assign out_payload_valid = out_result.payload_valid;
  assign out_payload_byte  = out_result.payload_byte;
  assign out_byte_index    = out_result.byte_index;
  assign out_frame_done    = out_result.frame_done;
  assign out_checksum_ok   = out_result.checksum_ok;
  assign out_length_error  = out_result.length_error;
  assign out_frame_type    = out_result.frame_type;
  assign out_frame_flags   = out_result.frame_flags;
  assign out_frame_seq     = out_result.frame_seq;
  assign out_frame_length  = out_result.frame_length;

  // A checksum verdict only comes with a finished frame.
  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_ok |-> out_frame_done)
    else $error("checksum_ok without frame_done");

  // A rejected header never carries payload or completes a frame.
  a_lerr_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_error |-> !out_payload_valid && !out_frame_done)
    else $error("length_error together with payload or frame_done");

  // Payload index always stays inside the header length.
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_byte_index < out_frame_length)
    else $error("payload index beyond frame length");

  // A beat waiting at the output is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_index))
    else $error("stalled result beat changed");

endmodule

>>> rtl/sbfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_parser
// Frame parser state and the per-byte update that produces one result beat.
// ----------------------------------------------------------------------------
module sbfd_parser import sbfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  sync_value,
  input  logic [15:0] max_payload_len,
  output result_t     result
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [7:0]  rsum_r, rsum_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] pcnt_r, pcnt_nxt;

  // Parser state, advanced once per byte taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      hcnt_r  <= '0;
      type_r  <= '0;
      flags_r <= '0;
      len_r   <= '0;
      seq_r   <= '0;
      rsum_r  <= '0;
      sum_r   <= '0;
      pcnt_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      type_r  <= type_nxt;
      flags_r <= flags_nxt;
      len_r   <= len_nxt;
      seq_r   <= seq_nxt;
      rsum_r  <= rsum_nxt;
      sum_r   <= sum_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

  // Next state and the result for the current byte.
  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    type_nxt  = type_r;
    flags_nxt = flags_r;
    len_nxt   = len_r;
    seq_nxt   = seq_r;
    rsum_nxt  = rsum_r;
    sum_nxt   = sum_r;
    pcnt_nxt  = pcnt_r;
    result    = '0;

    case (phase_r)
      PH_HEADER: begin
        if (hcnt_r < HDR_CHECKSUM) begin
          sum_nxt = sum_r + rx_byte;
        end
        case (hcnt_r)
          HDR_TYPE:   type_nxt  = rx_byte;
          HDR_FLAGS:  flags_nxt = rx_byte;
          HDR_LEN_HI: len_nxt   = {rx_byte, len_r[7:0]};
          HDR_LEN_LO: len_nxt   = {len_r[15:8], rx_byte};
          HDR_SEQ_HI: seq_nxt   = {rx_byte, seq_r[7:0]};
          HDR_SEQ_LO: seq_nxt   = {seq_r[15:8], rx_byte};
          default:    rsum_nxt  = rx_byte;
        endcase
        hcnt_nxt = hcnt_r + 3'd1;
        // The checksum byte closes the header.
        if (hcnt_r >= HDR_CHECKSUM) begin
          hcnt_nxt = '0;
          pcnt_nxt = '0;
          if (len_nxt > max_payload_len) begin
            result.length_error = 1'b1;
            phase_nxt = PH_HUNT;
          end else if (len_nxt == 16'd0) begin
            result.frame_done  = 1'b1;
            result.checksum_ok = (sum_nxt == rsum_nxt);
            phase_nxt = PH_HUNT;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = rx_byte;
        result.byte_index    = pcnt_r;
        sum_nxt  = sum_r + rx_byte;
        pcnt_nxt = pcnt_r + 16'd1;
        if (pcnt_nxt >= len_r) begin
          result.frame_done  = 1'b1;
          result.checksum_ok = (sum_nxt == rsum_r);
          phase_nxt = PH_HUNT;
          pcnt_nxt  = '0;
        end
      end
      default: begin
        // Hunting; an unused phase code hunts too.
        phase_nxt = PH_HUNT;
        if (rx_byte == sync_value) begin
          phase_nxt = PH_HEADER;
          hcnt_nxt  = '0;
          sum_nxt   = '0;
        end
      end
    endcase

    result.frame_type   = type_nxt;
    result.frame_flags  = flags_nxt;
    result.frame_seq    = seq_nxt;
    result.frame_length = len_nxt;
  end

endmodule

>>> rtl/sbfd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_out_stage
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module sbfd_out_stage import sbfd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result_in,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    can_load,
  output result_t result_out
);

  logic    valid_r;
  result_t data_r;

  // The register frees up when empty or when its beat is taken this cycle.
  assign can_load   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign result_out = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result_in;
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sync byte frame deframer against a cycle-free parser model.
// Received bytes go in from a backlog in random bursts. The receiver stalls
// on its own pattern. Every result beat is compared field by field with the
// parser model's prediction for the matching byte. The run covers
// zero-length frames, oversize lengths, bad checksums and truncated frames.
// The sync value and length limit are changed between phases, and the spare
// register addresses are written too.
// ----------------------------------------------------------------------------
module testbench import sbfd_pkg::*; ();

  // Spare register addresses; writes to them must be ignored.
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int RANDOM_BYTES = 400;
  localparam int MAX_PRINTED  = 50;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_payload_valid;
  logic [7:0]            out_payload_byte;
  logic [15:0]           out_byte_index;
  logic                  out_frame_done;
  logic                  out_checksum_ok;
  logic                  out_length_error;
  logic [7:0]            out_frame_type;
  logic [7:0]            out_frame_flags;
  logic [15:0]           out_frame_seq;
  logic [15:0]           out_frame_length;

  sync_byte_frame_deframer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_valid (out_payload_valid),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index),
    .out_frame_done    (out_frame_done),
    .out_checksum_ok   (out_checksum_ok),
    .out_length_error  (out_length_error),
    .out_frame_type    (out_frame_type),
    .out_frame_flags   (out_frame_flags),
    .out_frame_seq     (out_frame_seq),
    .out_frame_length  (out_frame_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bytes waiting to be sent, and result beats predicted but not yet seen.
  logic [7:0] rx_backlog[$];
  result_t    parsed_due[$];
  int         bytes_queued = 0;
  int         beats_checked = 0;
  int         mismatches = 0;

  // Register copies used by the parser model.
  logic [7:0]  link_sync = SYNC_RESET;
  logic [15:0] link_max_len = MAX_LEN_RESET;

  // Parser model state, at its reset values.
  phase_t      p_phase = PH_HUNT;
  logic [2:0]  p_hdr_cnt = '0;
  logic [7:0]  p_type = '0;
  logic [7:0]  p_flags = '0;
  logic [15:0] p_len = '0;
  logic [15:0] p_seq = '0;
  logic [7:0]  p_rx_sum = '0;
  logic [7:0]  p_run_sum = '0;
  logic [15:0] p_pay_cnt = '0;

  // Advances the parser model by one received byte and returns its result beat.
  function automatic result_t parse_rx_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (p_phase)
      PH_HEADER: begin
        if (p_hdr_cnt < HDR_CHECKSUM) p_run_sum = p_run_sum + b;
        case (p_hdr_cnt)
          HDR_TYPE:   p_type = b;
          HDR_FLAGS:  p_flags = b;
          HDR_LEN_HI: p_len[15:8] = b;
          HDR_LEN_LO: p_len[7:0] = b;
          HDR_SEQ_HI: p_seq[15:8] = b;
          HDR_SEQ_LO: p_seq[7:0] = b;
          default:    p_rx_sum = b;
        endcase
        if (p_hdr_cnt >= HDR_CHECKSUM) begin
          // Header complete: reject, finish an empty frame, or go to payload.
          p_hdr_cnt = '0;
          p_pay_cnt = '0;
          if (p_len > link_max_len) begin
            r.length_error = 1'b1;
            p_phase = PH_HUNT;
          end else if (p_len == 16'd0) begin
            r.frame_done = 1'b1;
            r.checksum_ok = (p_run_sum == p_rx_sum);
            p_phase = PH_HUNT;
          end else begin
            p_phase = PH_PAYLOAD;
          end
        end else begin
          p_hdr_cnt = p_hdr_cnt + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        r.byte_index = p_pay_cnt;
        p_run_sum = p_run_sum + b;
        p_pay_cnt = p_pay_cnt + 16'd1;
        if (p_pay_cnt >= p_len) begin
          r.frame_done = 1'b1;
          r.checksum_ok = (p_run_sum == p_rx_sum);
          p_phase = PH_HUNT;
          p_pay_cnt = '0;
        end
      end
      default: begin
        // Hunting; any other phase code behaves the same way.
        p_phase = PH_HUNT;
        if (b == link_sync) begin
          p_phase = PH_HEADER;
          p_hdr_cnt = '0;
          p_run_sum = '0;
        end
      end
    endcase
    r.frame_type = p_type;
    r.frame_flags = p_flags;
    r.frame_seq = p_seq;
    r.frame_length = p_len;
    return r;
  endfunction

  // Counts a mismatch and prints one line for it, up to a print limit.
  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("[%0t] beat %0d: %s", $time, beats_checked, what);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parsed_due.push_back(parse_rx_byte(in_rx_byte));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rx_backlog.size() != 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_backlog.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted beat and stalls in modes picked at random.
  int      stall_tick = 0;
  int      stall_mode = 0;
  result_t seen_beat;
  result_t want_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_beat = {out_payload_valid, out_payload_byte, out_byte_index, out_frame_done,
                     out_checksum_ok, out_length_error, out_frame_type, out_frame_flags,
                     out_frame_seq, out_frame_length};
        if (parsed_due.size() == 0) begin
          flag_mismatch("result beat with no byte outstanding");
        end else begin
          want_beat = parsed_due.pop_front();
          if (seen_beat.payload_valid !== want_beat.payload_valid)
            flag_mismatch($sformatf("payload_valid %0h, expected %0h",
                                    seen_beat.payload_valid, want_beat.payload_valid));
          if (seen_beat.payload_byte !== want_beat.payload_byte)
            flag_mismatch($sformatf("payload_byte %0h, expected %0h",
                                    seen_beat.payload_byte, want_beat.payload_byte));
          if (seen_beat.byte_index !== want_beat.byte_index)
            flag_mismatch($sformatf("byte_index %0h, expected %0h",
                                    seen_beat.byte_index, want_beat.byte_index));
          if (seen_beat.frame_done !== want_beat.frame_done)
            flag_mismatch($sformatf("frame_done %0h, expected %0h",
                                    seen_beat.frame_done, want_beat.frame_done));
          if (seen_beat.checksum_ok !== want_beat.checksum_ok)
            flag_mismatch($sformatf("checksum_ok %0h, expected %0h",
                                    seen_beat.checksum_ok, want_beat.checksum_ok));
          if (seen_beat.length_error !== want_beat.length_error)
            flag_mismatch($sformatf("length_error %0h, expected %0h",
                                    seen_beat.length_error, want_beat.length_error));
          if (seen_beat.frame_type !== want_beat.frame_type)
            flag_mismatch($sformatf("frame_type %0h, expected %0h",
                                    seen_beat.frame_type, want_beat.frame_type));
          if (seen_beat.frame_flags !== want_beat.frame_flags)
            flag_mismatch($sformatf("frame_flags %0h, expected %0h",
                                    seen_beat.frame_flags, want_beat.frame_flags));
          if (seen_beat.frame_seq !== want_beat.frame_seq)
            flag_mismatch($sformatf("frame_seq %0h, expected %0h",
                                    seen_beat.frame_seq, want_beat.frame_seq));
          if (seen_beat.frame_length !== want_beat.frame_length)
            flag_mismatch($sformatf("frame_length %0h, expected %0h",
                                    seen_beat.frame_length, want_beat.frame_length));
        end
        beats_checked++;
      end
      stall_tick++;
      if (stall_tick % 40 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (stall_tick % 5 < 3);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_queued++;
  endtask

  // Queues one frame under the current sync value. Payload follows only when
  // the length is within the limit. keep < 0 sends it whole, otherwise only
  // the first keep bytes.
  task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] fflags,
                             input logic [15:0] flen, input logic [15:0] fseq,
                             input bit bad_sum, input int keep);
    logic [7:0] frame_bytes[$];
    logic [7:0] body[$];
    logic [7:0] sum;
    int         n;
    frame_bytes = '{link_sync, ftype, fflags, flen[15:8], flen[7:0], fseq[15:8], fseq[7:0]};
    sum = ftype + fflags + flen[15:8] + flen[7:0] + fseq[15:8] + fseq[7:0];
    if (flen <= link_max_len) begin
      for (int i = 0; i < flen; i++) begin
        body.push_back(8'($urandom));
        sum = sum + body[i];
      end
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(sum);
    frame_bytes = {frame_bytes, body};
    n = (keep < 0 || keep > frame_bytes.size()) ? frame_bytes.size() : keep;
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i]);
  endtask

  // Queues a frame cut short somewhere in its header or payload.
  task automatic queue_cut_frame();
    logic [15:0] flen;
    flen = (link_max_len < 16'd8) ? link_max_len : 16'($urandom_range(0, 8));
    queue_frame(8'($urandom), 8'($urandom), flen, 16'($urandom), 1'b0,
                $urandom_range(1, 7 + flen));
  endtask

  // Queues a mix of frames and noise of about target bytes.
  task automatic fill_random(input int target);
    int          start;
    int          k;
    logic [15:0] lim;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      k = $urandom_range(0, 99);
      if (k < 70) begin
        // Well-formed frame, mostly short, with an occasional bad checksum.
        lim = (link_max_len < 16'd12) ? link_max_len : 16'd12;
        if ($urandom_range(0, 19) == 0) lim = (link_max_len < 16'd200) ? link_max_len : 16'd200;
        queue_frame(8'($urandom), 8'($urandom), 16'($urandom_range(0, lim)), 16'($urandom),
                    $urandom_range(0, 3) == 0, -1);
      end else if (k < 80 && link_max_len != 16'hFFFF) begin
        // Oversize length.
        queue_frame(8'($urandom), 8'($urandom),
                    16'($urandom_range(link_max_len + 1, 16'hFFFF)), 16'($urandom),
                    $urandom_range(0, 1) == 1, -1);
      end else if (k < 92) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        queue_cut_frame();
      end
    end
    // Sometimes leave the parser mid-frame across the next register change.
    if ($urandom_range(0, 2) == 0) queue_cut_frame();
  endtask

  // Waits until every queued byte has been sent and every beat checked.
  task automatic wait_quiet();
    @(negedge clk);
    while (rx_backlog.size() != 0 || in_valid || parsed_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    if (idx == CFG_SYNC_VALUE) link_sync = data[7:0];
    else if (idx == CFG_MAX_PAYLOAD) link_max_len = data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Random register settings for one phase.
  task automatic pick_config();
    int k;
    k = $urandom_range(0, 7);
    if (k < 3) begin
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_SYNC_VALUE, {8'($urandom), 8'h00});
        1:       write_reg(CFG_SYNC_VALUE, {8'($urandom), 8'hFF});
        2:       write_reg(CFG_SYNC_VALUE, {8'($urandom), SYNC_RESET});
        default: write_reg(CFG_SYNC_VALUE, 16'($urandom));
      endcase
    end
    if (k >= 2 && k <= 5) begin
      case ($urandom_range(0, 4))
        0:       write_reg(CFG_MAX_PAYLOAD, 16'd0);
        1:       write_reg(CFG_MAX_PAYLOAD, 16'hFFFF);
        2:       write_reg(CFG_MAX_PAYLOAD, MAX_LEN_RESET);
        3:       write_reg(CFG_MAX_PAYLOAD, 16'($urandom_range(0, 20)));
        default: write_reg(CFG_MAX_PAYLOAD, 16'($urandom));
      endcase
    end
    if (k == 6) write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
  endtask

  // Stimulus and end of run.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero-length frame with extreme header fields and a good checksum.
    queue_frame(8'hFF, 8'h00, 16'd0, 16'hFFFF, 1'b0, -1);
    // Three-byte frame whose checksum and payload carry the sync value as data;
    // the checksum is wrong.
    send_byte(SYNC_RESET);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(SYNC_RESET);
    send_byte(8'h00);
    send_byte(SYNC_RESET);
    send_byte(8'hFF);
    // Length one above the limit: length error, back to hunting.
    queue_frame(8'h12, 8'h34, MAX_LEN_RESET + 16'd1, 16'h8000, 1'b0, -1);
    wait_quiet();

    // Extreme register settings, then spare addresses, then random phases.
    write_reg(CFG_SYNC_VALUE, 16'hFF00);
    write_reg(CFG_MAX_PAYLOAD, 16'd0);
    fill_random(40);
    wait_quiet();
    write_reg(CFG_SYNC_VALUE, 16'h00FF);
    write_reg(CFG_MAX_PAYLOAD, 16'hFFFF);
    fill_random(40);
    wait_quiet();
    write_reg(CFG_SPARE_LO, 16'($urandom));
    write_reg(CFG_SPARE_HI, 16'($urandom));
    write_reg(CFG_MAX_PAYLOAD, 16'd5);
    fill_random(30);
    while (bytes_queued < RANDOM_BYTES) begin
      wait_quiet();
      pick_config();
      fill_random($urandom_range(20, 60));
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
